[hdl/pending_ack_retransmit_table_core_defines.svh]
// ----------------------------------------------------------------------------
// pending ack table assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef PENDING_ACK_RETRANSMIT_TABLE_CORE_DEFINES_SVH
`define PENDING_ACK_RETRANSMIT_TABLE_CORE_DEFINES_SVH

// implication checked on every rising edge outside reset
`define PART_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("pending ack table: property violated");

// signal holds its value in the cycle after a condition
`define PART_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("pending ack table: value changed while held");

`endif

[hdl/part_pkg.sv]
// ----------------------------------------------------------------------------
// pending ack table package
// shared widths, codes, state type and controller/datapath link types
// ----------------------------------------------------------------------------
package part_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int OP_W      = 2;
	localparam int ID_W      = 14;
	localparam int TAG_W     = 16;
	localparam int TIME_W    = 32;
	localparam int KIND_W    = 3;
	localparam int SLOT_W    = 6;

	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd20000;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_SCAN   = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERTED  = 3'd0,
		KIND_REMOVED   = 3'd1,
		KIND_NOT_FOUND = 3'd2,
		KIND_IN_USE    = 3'd3,
		KIND_FREE      = 3'd4,
		KIND_TIMED_OUT = 3'd5,
		KIND_NONE      = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_WALK,
		ST_FINISH
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic insert;
		logic walk;
		logic finish;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic walk_done;
		logic push_ok;
	} dp_sts_t;

endpackage

[hdl/part_ctrl.sv]
// ----------------------------------------------------------------------------
// pending ack table controller
// sequences insert, table walk and final result push for one item at a time
// ----------------------------------------------------------------------------
module part_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [part_pkg::OP_W-1:0]  operation,
	input  part_pkg::dp_sts_t          sts,
	output part_pkg::ctrl_cmd_t        cmd
);
	import part_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = (op_t'(operation) == OP_INSERT) ? ST_INSERT : ST_WALK;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_nxt  = ST_FINISH;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				if (sts.push_ok) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/part_dp.sv]
// ----------------------------------------------------------------------------
// pending ack table datapath
// slot memories, one-slot-per-cycle walk unless a scan stall holds it, pending scan hit and output register
// ----------------------------------------------------------------------------
module part_dp #(
	parameter int DEPTH = part_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  part_pkg::ctrl_cmd_t           cmd,
	output part_pkg::dp_sts_t             sts,
	input  logic                          cfg_valid,
	input  logic [part_pkg::TIME_W-1:0]   cfg_data,
	input  logic [part_pkg::OP_W-1:0]     operation,
	input  logic [part_pkg::ID_W-1:0]     message_id,
	input  logic [part_pkg::TAG_W-1:0]    payload_tag,
	input  logic [part_pkg::TIME_W-1:0]   now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [part_pkg::KIND_W-1:0]   result_kind,
	output logic [part_pkg::SLOT_W-1:0]   slot,
	output logic [part_pkg::ID_W-1:0]     found_id,
	output logic [part_pkg::TAG_W-1:0]    found_tag,
	output logic                          last
);
	import part_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// slot memories
	logic [ID_W-1:0]   id_mem  [DEPTH];
	logic [TAG_W-1:0]  tag_mem [DEPTH];
	logic [TIME_W-1:0] tm_mem  [DEPTH];
	logic [DEPTH-1:0]  id_vld_q;
	logic [DEPTH-1:0]  tm_vld_q;

	logic [TIME_W-1:0] timeout_q;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     ins_slot_q;

	// latched item
	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	logic [TAG_W-1:0]  tag_q;
	logic [TIME_W-1:0] now_q;

	// walk state
	logic [AW-1:0]     rd_addr_q;
	logic              rd_done_q;
	logic              vld_s1;
	logic [AW-1:0]     slot_s1;
	logic [ID_W-1:0]   id_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [TIME_W-1:0] tm_s1;
	logic              idv_s1;
	logic              tmv_s1;

	// search result and pending scan hit
	logic              hit_q;
	logic [AW-1:0]     first_q;
	logic              pend_vld_q;
	logic [AW-1:0]     pend_slot_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [TAG_W-1:0]  pend_tag_q;

	// output register
	logic              out_vld_q;
	logic [KIND_W-1:0] kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ID_W-1:0]   fid_q;
	logic [TAG_W-1:0]  ftag_q;
	logic              last_q;

	logic              push_ok;
	logic              stall;
	logic              adv;
	logic              rd_en;
	logic              eval;
	logic [ID_W-1:0]   eid;
	logic [TIME_W-1:0] etime;
	logic [TIME_W-1:0] age;
	logic              match;
	logic              timed;
	logic              scan_hit;
	logic              scan_push;
	logic              final_push;
	logic [KIND_W-1:0] fin_kind;
	logic [SLOT_W-1:0] fin_slot;
	logic [ID_W-1:0]   fin_id;
	logic [TAG_W-1:0]  fin_tag;

	// slot evaluation on the registered read data
	always_comb begin
		eid      = idv_s1 ? id_s1 : '0;
		etime    = tmv_s1 ? tm_s1 : '0;
		age      = now_q - etime;
		match    = (id_q != '0) && (eid == id_q);
		timed    = (eid != '0) && (etime != '0) && (age > timeout_q);
		scan_hit = vld_s1 && (op_q == OP_SCAN) && timed;
	end

	// walk advance and stall
	assign push_ok    = !out_vld_q || out_ready;
	assign stall      = cmd.walk && scan_hit && pend_vld_q && !push_ok;
	assign adv        = cmd.walk && !stall;
	assign rd_en      = adv && !rd_done_q;
	assign eval       = adv && vld_s1;
	assign scan_push  = eval && scan_hit && pend_vld_q;
	assign final_push = cmd.finish && push_ok;

	assign sts.walk_done = rd_done_q && !vld_s1;
	assign sts.push_ok   = push_ok;

	// final result of the item
	always_comb begin
		fin_kind = KIND_NONE;
		fin_slot = '0;
		fin_id   = id_q;
		fin_tag  = '0;
		case (op_q)
			OP_INSERT: begin
				fin_kind = KIND_INSERTED;
				fin_slot = SLOT_W'(ins_slot_q);
				fin_tag  = tag_q;
			end
			OP_REMOVE: begin
				fin_kind = hit_q ? KIND_REMOVED : KIND_NOT_FOUND;
				fin_slot = SLOT_W'(first_q);
			end
			OP_QUERY: begin
				fin_kind = hit_q ? KIND_IN_USE : KIND_FREE;
				fin_slot = SLOT_W'(first_q);
			end
			OP_SCAN: begin
				if (pend_vld_q) begin
					fin_kind = KIND_TIMED_OUT;
					fin_slot = SLOT_W'(pend_slot_q);
					fin_id   = pend_id_q;
					fin_tag  = pend_tag_q;
				end else begin
					fin_kind = KIND_NONE;
					fin_id   = '0;
				end
			end
			default: begin
				fin_kind = KIND_NONE;
			end
		endcase
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(operation);
			id_q  <= message_id;
			tag_q <= payload_tag;
			now_q <= now_ms;
		end
		if (cmd.insert) begin
			ins_slot_q <= wp_q;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			id_mem[wp_q]  <= id_q;
			tag_mem[wp_q] <= tag_q;
			tm_mem[wp_q]  <= now_q;
		end
		if (rd_en) begin
			id_s1   <= id_mem[rd_addr_q];
			tag_s1  <= tag_mem[rd_addr_q];
			tm_s1   <= tm_mem[rd_addr_q];
			idv_s1  <= id_vld_q[rd_addr_q];
			tmv_s1  <= tm_vld_q[rd_addr_q];
			slot_s1 <= rd_addr_q;
		end
	end

	// entry valid bits and write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_vld_q <= '0;
			tm_vld_q <= '0;
			wp_q     <= '0;
		end else begin
			if (cmd.insert) begin
				id_vld_q[wp_q] <= 1'b1;
				tm_vld_q[wp_q] <= 1'b1;
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (eval && (op_q == OP_REMOVE) && match) begin
				id_vld_q[slot_s1] <= 1'b0;
			end
		end
	end

	// walk counter and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q  <= '0;
			rd_done_q  <= 1'b0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			first_q    <= '0;
			pend_vld_q <= 1'b0;
		end else if (cmd.accept) begin
			rd_addr_q  <= '0;
			rd_done_q  <= 1'b0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			first_q    <= '0;
			pend_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !rd_done_q;
			if (!rd_done_q) begin
				rd_addr_q <= rd_addr_q + AW'(1);
				if (rd_addr_q == AW'(DEPTH - 1)) begin
					rd_done_q <= 1'b1;
				end
			end
			if (eval && (op_q != OP_SCAN) && match) begin
				hit_q <= 1'b1;
				if (!hit_q) begin
					first_q <= slot_s1;
				end
			end
			if (eval && scan_hit) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	// pending scan hit payload
	always_ff @(posedge clk) begin
		if (eval && scan_hit) begin
			pend_slot_q <= slot_s1;
			pend_id_q   <= eid;
			pend_tag_q  <= tag_s1;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (scan_push || final_push) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (scan_push) begin
			kind_q <= KIND_TIMED_OUT;
			slot_q <= SLOT_W'(pend_slot_q);
			fid_q  <= pend_id_q;
			ftag_q <= pend_tag_q;
			last_q <= 1'b0;
		end else if (final_push) begin
			kind_q <= fin_kind;
			slot_q <= fin_slot;
			fid_q  <= fin_id;
			ftag_q <= fin_tag;
			last_q <= 1'b1;
		end
	end

	assign out_valid   = out_vld_q;
	assign result_kind = kind_q;
	assign slot        = slot_q;
	assign found_id    = fid_q;
	assign found_tag   = ftag_q;
	assign last        = last_q;

endmodule

[hdl/pending_ack_retransmit_table_core.sv]
// ----------------------------------------------------------------------------
// pending ack retransmit table core
// table of unacknowledged messages with insert, remove, query and timeout scan
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready) takes one item: operation, message_id,
//   payload_tag, now_ms. out channel (out_valid/out_ready) gives result items;
//   the final result of an item has last set. cfg channel writes timeout_ms.
// sequencing
//   insert passes through ST_INSERT and ST_FINISH; its result enters the
//   output register in ST_FINISH once that register is free. remove, query
//   and scan walk every slot through a single memory read port, one slot
//   per cycle while the walk is not stalled, then push the final result.
//   a new item can be accepted in the cycle after the previous final
//   result is pushed to the output register, even if it is not yet taken.
// stalls
//   a scan holds one timed out hit aside; when the next hit arrives and the
//   output register is still full, the walk halts until out_ready frees it.
// reset
//   arst_n clears all slots to empty, the write pointer to zero and the
//   timeout to 20000 ms at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pending_ack_retransmit_table_core #(
	parameter int DEPTH = part_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [part_pkg::TIME_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [part_pkg::OP_W-1:0]     operation,
	input  logic [part_pkg::ID_W-1:0]     message_id,
	input  logic [part_pkg::TAG_W-1:0]    payload_tag,
	input  logic [part_pkg::TIME_W-1:0]   now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [part_pkg::KIND_W-1:0]   result_kind,
	output logic [part_pkg::SLOT_W-1:0]   slot,
	output logic [part_pkg::ID_W-1:0]     found_id,
	output logic [part_pkg::TAG_W-1:0]    found_tag,
	output logic                          last
);
	import part_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// controller
	part_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	part_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.message_id  (message_id),
		.payload_tag (payload_tag),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.slot        (slot),
		.found_id    (found_id),
		.found_tag   (found_tag),
		.last        (last)
	);

endmodule

[hdl/part_chk.sv]
// ----------------------------------------------------------------------------
// pending ack table port checker
// port-level properties over time, bound to the core
// ----------------------------------------------------------------------------
`include "pending_ack_retransmit_table_core_defines.svh"

module part_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [part_pkg::KIND_W-1:0]   result_kind,
	input logic                          last
);
	import part_pkg::*;

	// one item at a time: an accepted item has the input closed in the following cycle
	`PART_ASSERT(a_one_item, clk, arst_n, (in_valid && in_ready) |=> !in_ready)

	// only timed out entries may be followed by more results of the same item
	`PART_ASSERT(a_last_mark, clk, arst_n, (out_valid && (result_kind != KIND_TIMED_OUT)) |-> last)

	// a stalled result stays offered
	`PART_ASSERT(a_out_hold_vld, clk, arst_n, (out_valid && !out_ready) |=> out_valid)

	// a stalled result keeps its kind
	`PART_ASSERT_HOLD(a_out_hold_kind, clk, arst_n, (out_valid && !out_ready), result_kind)

endmodule

bind pending_ack_retransmit_table_core part_chk u_part_chk (.*);
